/* rtl/pwf_pkg.sv */
// package for the plateau window finder: parameter defaults, widths, register indexes and reset values
package pwf_pkg;

	// parameter defaults
	localparam int DEF_MAX_TIME_EXTENT = 256;
	localparam int DEF_VALUE_WIDTH     = 32;

	// fixed field and register widths
	localparam int TARGET_VALUE_W = 32;
	localparam int TARGET_ERROR_W = 31;
	localparam int EXTENT_W       = 9;
	localparam int GAP_W          = 8;
	localparam int OUT_IDX_W      = 7;
	localparam int CFG_DATA_W     = 32;
	localparam int CFG_INDEX_W    = 2;
	localparam int OUT_DATA_W     = 16;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TARGET_VALUE = 2'd0,
		REG_TARGET_ERROR = 2'd1,
		REG_TIME_EXTENT  = 2'd2,
		REG_GAP_LIMIT    = 2'd3
	} cfg_reg_t;

	// register reset values
	localparam logic [EXTENT_W-1:0] TIME_EXTENT_RST = 9'd64;
	localparam logic [GAP_W-1:0]    GAP_LIMIT_RST   = 8'd4;

endpackage

/* rtl/plateau_window_finder.sv */
// top level of the plateau window finder: band test, run merging and best window tracking
//
//   channel   dir   handshake               payload
//   s_axis    in    s_axis_tvalid/tready    tdata: sample_value, sample_error
//   m_axis    out   m_axis_tvalid/tready    tdata: plateau_start, plateau_end; tuser: found
//   cfg       in    cfg_wr_en               cfg_index, cfg_data
//
// one beat per cycle unless a result stalls; the result register follows the stage register
// the band test (subtracts, adds and compares) sits before the stage register, the run and
// merge bookkeeping (two short length compares) before the result register
// a result is given on the last sample of each pass, then the pass state clears
// a stalled result holds the whole pipe; the input stage still fills while it waits
// arst_n clears all control state and loads the register reset values
module plateau_window_finder
	import pwf_pkg::*;
#(
	parameter int MAX_TIME_EXTENT = DEF_MAX_TIME_EXTENT,
	parameter int VALUE_WIDTH     = DEF_VALUE_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	// sample_value [VALUE_WIDTH-1:0], sample_error [2*VALUE_WIDTH-2:VALUE_WIDTH], zero pad
	input  logic [((2*VALUE_WIDTH-1+7)/8)*8-1:0] s_axis_tdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// plateau_start [6:0], plateau_end [13:7], zero pad [15:14]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// plateau_found [0]
	output logic m_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W_RAW = $clog2(MAX_TIME_EXTENT / 2);
	localparam int IDX_W     = (IDX_W_RAW < 1) ? 1 : IDX_W_RAW;
	localparam int EXT_EFF_W = $clog2(MAX_TIME_EXTENT + 1);
	localparam int CMP_W     = GAP_W + IDX_W;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] start;
		logic [IDX_W-1:0] stop;
	} interval_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] start;
		logic [IDX_W-1:0] stop;
		logic [IDX_W-1:0] length;
	} best_t;

	// configuration registers
	logic [TARGET_VALUE_W-1:0] target_value_q;
	logic [TARGET_ERROR_W-1:0] target_error_q;
	logic [EXTENT_W-1:0]       time_extent_q;
	logic [GAP_W-1:0]          gap_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_value_q <= '0;
			target_error_q <= '0;
			time_extent_q  <= TIME_EXTENT_RST;
			gap_limit_q    <= GAP_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_TARGET_VALUE: target_value_q <= cfg_data[TARGET_VALUE_W-1:0];
				REG_TARGET_ERROR: target_error_q <= cfg_data[TARGET_ERROR_W-1:0];
				REG_TIME_EXTENT:  time_extent_q  <= cfg_data[EXTENT_W-1:0];
				REG_GAP_LIMIT:    gap_limit_q    <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// band test on the incoming beat
	logic [VALUE_WIDTH-1:0]              sample_value;
	logic [VALUE_WIDTH-2:0]              sample_error;
	logic [VALUE_WIDTH+TARGET_VALUE_W-1:0] target_value_wide;
	logic [VALUE_WIDTH+TARGET_ERROR_W-1:0] target_error_wide;
	logic [VALUE_WIDTH-1:0]              target_v;
	logic [VALUE_WIDTH-2:0]              target_e;
	logic                                value_ge;
	logic [VALUE_WIDTH:0]                value_dist;
	logic [VALUE_WIDTH-1:0]              err_sum;
	logic                                inband;

	assign sample_value      = s_axis_tdata[VALUE_WIDTH-1:0];
	assign sample_error      = s_axis_tdata[2*VALUE_WIDTH-2:VALUE_WIDTH];
	assign target_value_wide = {{VALUE_WIDTH{1'b0}}, target_value_q};
	assign target_error_wide = {{VALUE_WIDTH{1'b0}}, target_error_q};
	assign target_v          = target_value_wide[VALUE_WIDTH-1:0];
	assign target_e          = target_error_wide[VALUE_WIDTH-2:0];
	assign value_ge          = $signed(sample_value) >= $signed(target_v);
	assign value_dist        = value_ge
		? ({sample_value[VALUE_WIDTH-1], sample_value} - {target_v[VALUE_WIDTH-1], target_v})
		: ({target_v[VALUE_WIDTH-1], target_v} - {sample_value[VALUE_WIDTH-1], sample_value});
	assign err_sum           = {1'b0, sample_error} + {1'b0, target_e};
	assign inband            = value_dist < {1'b0, err_sum};

	// pipe control
	logic s1_valid_s1;
	logic inband_s1;
	logic advance;
	logic step;
	logic out_valid_q;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !s1_valid_s1 || advance;
	assign step          = s1_valid_s1 && advance;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			inband_s1 <= inband;
		end
	end

	// pass state
	logic [IDX_W-1:0] time_index_q;
	logic             in_run_q;
	logic [IDX_W-1:0] run_start_q;
	interval_t        merged_q;
	best_t            best_q;

	// effective extent and last index of the pass
	logic [EXTENT_W-1:0]     ext_clamped;
	logic [EXT_EFF_W-1:0]    ext_eff;
	logic [EXT_EFF_W-1:0]    half_ext;
	logic [EXT_EFF_W-1:0]    last_full;
	logic [IDX_W-1:0]        last_idx;
	logic [EXT_EFF_W+OUT_IDX_W-1:0] quarter_wide;

	assign ext_clamped  = (time_extent_q > EXTENT_W'(MAX_TIME_EXTENT))
		? EXTENT_W'(MAX_TIME_EXTENT) : time_extent_q;
	assign ext_eff      = ext_clamped[EXT_EFF_W-1:0];
	assign half_ext     = ext_eff >> 1;
	assign last_full    = (half_ext >= EXT_EFF_W'(2)) ? (half_ext - EXT_EFF_W'(1))
		: EXT_EFF_W'(1);
	assign last_idx     = last_full[IDX_W-1:0];
	assign quarter_wide = {{OUT_IDX_W{1'b0}}, ext_eff} >> 2;

	// run closing, merging and best tracking for the staged sample
	logic             is_last;
	logic             start_run;
	logic             close_run;
	logic [IDX_W-1:0] gap_diff;
	logic             merge_ok;
	logic [IDX_W-1:0] merged_len;
	logic [IDX_W-1:0] merged1_len;
	interval_t        merged1;
	best_t            best1;
	best_t            best2;

	always_comb begin
		is_last     = time_index_q >= last_idx;
		start_run   = !in_run_q && inband_s1 && !is_last;
		close_run   = in_run_q && (!inband_s1 || is_last);
		gap_diff    = run_start_q - merged_q.stop;
		merge_ok    = merged_q.valid && (CMP_W'(gap_diff) < CMP_W'(gap_limit_q));
		merged_len  = merged_q.stop - merged_q.start;
		merged1     = merged_q;
		best1       = best_q;
		if (close_run) begin
			if (merge_ok) begin
				merged1.stop = time_index_q;
			end else begin
				if (merged_q.valid && (!best_q.valid || merged_len > best_q.length)) begin
					best1.valid  = 1'b1;
					best1.start  = merged_q.start;
					best1.stop   = merged_q.stop;
					best1.length = merged_len;
				end
				merged1.valid = 1'b1;
				merged1.start = run_start_q;
				merged1.stop  = time_index_q;
			end
		end
		// final commit at the end of the pass
		merged1_len = merged1.stop - merged1.start;
		best2       = best1;
		if (merged1.valid && (!best1.valid || merged1_len > best1.length)) begin
			best2.valid  = 1'b1;
			best2.start  = merged1.start;
			best2.stop   = merged1.stop;
			best2.length = merged1_len;
		end
	end

	// pass state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_index_q <= IDX_W'(1);
			in_run_q     <= 1'b0;
			run_start_q  <= '0;
			merged_q     <= '0;
			best_q       <= '0;
		end else if (step) begin
			if (is_last) begin
				time_index_q <= IDX_W'(1);
				in_run_q     <= 1'b0;
				run_start_q  <= '0;
				merged_q     <= '0;
				best_q       <= '0;
			end else begin
				time_index_q <= time_index_q + IDX_W'(1);
				merged_q     <= merged1;
				best_q       <= best1;
				if (start_run) begin
					in_run_q    <= 1'b1;
					run_start_q <= time_index_q;
				end else if (close_run) begin
					in_run_q <= 1'b0;
				end
			end
		end
	end

	// result register
	logic [OUT_IDX_W-1:0] out_start_q;
	logic [OUT_IDX_W-1:0] out_end_q;
	logic                 out_found_q;
	logic [IDX_W-1:0]     best_last;

	assign best_last = best2.stop - IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (step && is_last) begin
			if (best2.valid) begin
				out_start_q <= OUT_IDX_W'(best2.start);
				out_end_q   <= OUT_IDX_W'(best_last);
				out_found_q <= 1'b1;
			end else begin
				out_start_q <= quarter_wide[OUT_IDX_W-1:0];
				out_end_q   <= quarter_wide[OUT_IDX_W-1:0];
				out_found_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-2*OUT_IDX_W){1'b0}}, out_end_q, out_start_q};
	assign m_axis_tuser  = out_found_q;

`ifndef SYNTHESIS
	// default window is a single index
	a_default_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> out_start_q == out_end_q)
		else $error("default window start and end differ");

	// a found plateau never ends before it starts
	a_found_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> out_start_q <= out_end_q)
		else $error("plateau ends before it starts");

	// an open run always began at an earlier index
	a_run_before_index: assert property (@(posedge clk) disable iff (!arst_n)
		in_run_q |-> run_start_q < time_index_q)
		else $error("open run starts at or after current index");

	// an open run starts after the merged interval closed
	a_run_after_merged: assert property (@(posedge clk) disable iff (!arst_n)
		in_run_q && merged_q.valid |-> merged_q.stop < run_start_q)
		else $error("open run overlaps merged interval");
`endif

endmodule
